// ===== rtl/core/ddal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ddal_pkg;

  // Reference and fraction formats
  localparam int VEL_BITS   = 20;
  localparam int FRAC_BITS  = 12;

  // Field widths of the channels
  localparam int VEL_IN_W   = 20;
  localparam int TURN_W     = 20;
  localparam int PER_W      = 16;
  localparam int OUT_W      = 20;
  localparam int WB_W       = 14;
  localparam int ACC_W      = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL   = 2'd1;

  // Datapath widths
  localparam int DIFP_W  = WB_W + TURN_W;             // track width * |yaw rate|
  localparam int DIFM_W  = DIFP_W - FRAC_BITS - 1;    // magnitude of the half difference
  localparam int DIF_W   = DIFM_W + 1;
  localparam int TGT_W   = ((DIF_W > VEL_IN_W) ? DIF_W : VEL_IN_W) + 1;
  localparam int D_W     = ((TGT_W > VEL_BITS) ? TGT_W : VEL_BITS) + 1;
  localparam int MAG_W   = D_W - 1;
  localparam int LIM_W   = ACC_W + PER_W;
  localparam int US_W    = 20;
  localparam int DEN_W   = MAG_W + US_W;
  localparam int Q_W     = MAG_W;
  localparam int MUL_A_W = MAG_W;
  localparam int MUL_B_W = LIM_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int NUM_W   = PROD_W;
  localparam int CNT_W   = $clog2(Q_W + 1);
  localparam int S_W     = D_W + 1;

  localparam logic [US_W-1:0] US_PER_S = 20'd1000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIF,
    ST_LIM,
    ST_DELTA,
    ST_MAG,
    ST_MAX,
    ST_DEN,
    ST_CMP,
    ST_NUM_R,
    ST_DIV_R,
    ST_WAIT_R,
    ST_NUM_L,
    ST_DIV_L,
    ST_WAIT_L,
    ST_UPD
  } ddal_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ddal_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ddal_in_if import ddal_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VEL_IN_W-1:0] velocity_cmd;
  logic signed [TURN_W-1:0]   yaw_rate;
  logic [PER_W-1:0]           step_period_us;

  modport source (output valid, velocity_cmd, yaw_rate, step_period_us, input ready);
  modport sink   (input valid, velocity_cmd, yaw_rate, step_period_us, output ready);
  modport mon    (input valid, ready, velocity_cmd, yaw_rate, step_period_us);
endinterface

interface ddal_out_if import ddal_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] right_ref;
  logic signed [OUT_W-1:0] left_ref;
  logic                    accel_limited;

  modport source (output valid, right_ref, left_ref, accel_limited, input ready);
  modport sink   (input valid, right_ref, left_ref, accel_limited, output ready);
  modport mon    (input valid, ready, right_ref, left_ref, accel_limited);
endinterface

interface ddal_cfg_if import ddal_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface
`default_nettype wire

// ===== rtl/core/ddal_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ddal_div import ddal_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [Q_W-1:0]   low_r;
  logic [Q_W-1:0]   q_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fit;
  logic [DEN_W-1:0] rem_nxt;

  // Quotient is known to fit Q_W bits, so the top part of num starts below den.
  assign trial   = {rem_r, low_r[Q_W-1]};
  assign diff    = trial - {1'b0, den};
  assign fit     = trial >= {1'b0, den};
  assign rem_nxt = fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(Q_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num[NUM_W-1:Q_W]);
      low_r <= num[Q_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], fit};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/diff_drive_accel_limited_wheel_refs_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted request runs through the sequencer states to a valid result; when the change
// exceeds the limit, it is scaled by two 23-step divisions on the shared divider on the way.
// One request at a time: a new one is taken only once the previous result has entered the
// output register, which waits while the output is stalled; the sequencer around one shared
// multiplier and one restoring divider sets this pace.
// Reset (synchronous, active low): wheel references to zero, track width 983, max_accel 4096.
module diff_drive_accel_limited_wheel_refs_unit import ddal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ddal_in_if.sink    in_req,
  ddal_out_if.source out_res,
  ddal_cfg_if.sink   cfg_wr
);

  ddal_state_t state_r, state_nxt;

  logic [WB_W-1:0]            track_width_r;
  logic [ACC_W-1:0]           max_accel_r;
  logic signed [VEL_BITS-1:0] right_ref_r;
  logic signed [VEL_BITS-1:0] left_ref_r;

  logic signed [VEL_IN_W-1:0] vel_r;
  logic                       turn_neg_r;
  logic [TURN_W-1:0]          turn_mag_r;
  logic [PER_W-1:0]           period_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [DIF_W-1:0]    dif_r;
  logic [LIM_W-1:0]           lim_r;
  logic signed [D_W-1:0]      d_r_r;
  logic signed [D_W-1:0]      d_l_r;
  logic [MAG_W-1:0]           mag_r_r;
  logic [MAG_W-1:0]           mag_l_r;
  logic [MAG_W-1:0]           m_r;
  logic [DEN_W-1:0]           den_r;
  logic                       limited_r;
  logic [Q_W-1:0]             q_r_r;
  logic [Q_W-1:0]             q_l_r;

  logic                       out_valid_r;
  logic signed [OUT_W-1:0]    out_right_r;
  logic signed [OUT_W-1:0]    out_left_r;
  logic                       out_lim_r;

  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [PROD_W-1:0]          mul_p;
  logic                       div_start;
  logic                       div_done;
  logic [Q_W-1:0]             div_quot;
  logic                       in_ready;
  logic                       in_take;
  logic                       out_free;
  logic [DIFM_W-1:0]          dif_mag;
  logic signed [DIF_W-1:0]    dif_ext;
  logic signed [D_W-1:0]      d_sel_r;
  logic signed [D_W-1:0]      d_sel_l;
  logic signed [VEL_BITS-1:0] right_new;
  logic signed [VEL_BITS-1:0] left_new;

  localparam logic signed [S_W-1:0] VEL_MAX = {{(S_W-VEL_BITS+1){1'b0}}, {(VEL_BITS-1){1'b1}}};
  localparam logic signed [S_W-1:0] VEL_MIN = {{(S_W-VEL_BITS+1){1'b1}}, {(VEL_BITS-1){1'b0}}};

  function automatic logic [MAG_W-1:0] abs_d(input logic signed [D_W-1:0] v);
    logic signed [D_W-1:0] n;
    n = v[D_W-1] ? -v : v;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic signed [VEL_BITS-1:0] step_ref(
    input logic signed [VEL_BITS-1:0] r,
    input logic signed [D_W-1:0]      d
  );
    logic signed [S_W-1:0] s;
    s = S_W'(r) + S_W'(d);
    if (s > VEL_MAX) begin
      s = VEL_MAX;
    end else if (s < VEL_MIN) begin
      s = VEL_MIN;
    end
    return s[VEL_BITS-1:0];
  endfunction

  function automatic logic signed [D_W-1:0] signed_q(
    input logic                  neg,
    input logic [Q_W-1:0]        q
  );
    logic signed [D_W-1:0] p;
    p = signed'({1'b0, q});
    return neg ? -p : p;
  endfunction

  ddal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r[NUM_W-1:0]),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_take  = in_req.valid && in_ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign mul_p    = mul_a * mul_b;

  assign dif_mag  = prod_r[DIFP_W-1:FRAC_BITS+1];
  assign dif_ext  = signed'({1'b0, dif_mag});

  assign d_sel_r   = limited_r ? signed_q(d_r_r[D_W-1], q_r_r) : d_r_r;
  assign d_sel_l   = limited_r ? signed_q(d_l_r[D_W-1], q_l_r) : d_l_r;
  assign right_new = step_ref(right_ref_r, d_sel_r);
  assign left_new  = step_ref(left_ref_r, d_sel_l);

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        // no request is taken while reset is held
        in_ready = rst_n;
        if (in_req.valid) begin
          state_nxt = ST_DIF;
        end
      end
      ST_DIF: begin
        mul_a     = MUL_A_W'(turn_mag_r);
        mul_b     = MUL_B_W'(track_width_r);
        state_nxt = ST_LIM;
      end
      ST_LIM: begin
        mul_a     = MUL_A_W'(max_accel_r);
        mul_b     = MUL_B_W'(period_r);
        state_nxt = ST_DELTA;
      end
      ST_DELTA: state_nxt = ST_MAG;
      ST_MAG:   state_nxt = ST_MAX;
      ST_MAX:   state_nxt = ST_DEN;
      ST_DEN: begin
        mul_a     = m_r;
        mul_b     = MUL_B_W'(US_PER_S);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = (prod_r[DEN_W-1:0] > DEN_W'(lim_r)) ? ST_NUM_R : ST_UPD;
      end
      ST_NUM_R: begin
        mul_a     = mag_r_r;
        mul_b     = lim_r;
        state_nxt = ST_DIV_R;
      end
      ST_DIV_R: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT_R;
      end
      ST_WAIT_R: begin
        if (div_done) begin
          state_nxt = ST_NUM_L;
        end
      end
      ST_NUM_L: begin
        mul_a     = mag_l_r;
        mul_b     = lim_r;
        state_nxt = ST_DIV_L;
      end
      ST_DIV_L: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT_L;
      end
      ST_WAIT_L: begin
        if (div_done) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_width_r <= WB_W'(983);
      max_accel_r   <= ACC_W'(4096);
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_TRACK_WIDTH: track_width_r <= cfg_wr.data[WB_W-1:0];
        CFG_MAX_ACCEL:   max_accel_r   <= cfg_wr.data[ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_ref_r <= '0;
      left_ref_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_UPD && out_free) begin
        right_ref_r <= right_new;
        left_ref_r  <= left_new;
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD && out_free) begin
      out_right_r <= OUT_W'(right_new);
      out_left_r  <= OUT_W'(left_new);
      out_lim_r   <= limited_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          vel_r      <= in_req.velocity_cmd;
          turn_neg_r <= in_req.yaw_rate[TURN_W-1];
          turn_mag_r <= in_req.yaw_rate[TURN_W-1] ? (~in_req.yaw_rate + 1'b1)
                                                  : in_req.yaw_rate;
          period_r   <= in_req.step_period_us;
        end
      end
      ST_DIF: prod_r <= mul_p;
      ST_LIM: begin
        dif_r  <= turn_neg_r ? -dif_ext : dif_ext;
        prod_r <= mul_p;
      end
      ST_DELTA: begin
        lim_r <= prod_r[LIM_W-1:0];
        d_r_r <= D_W'(vel_r) + D_W'(dif_r) - D_W'(right_ref_r);
        d_l_r <= D_W'(vel_r) - D_W'(dif_r) - D_W'(left_ref_r);
      end
      ST_MAG: begin
        mag_r_r <= abs_d(d_r_r);
        mag_l_r <= abs_d(d_l_r);
      end
      ST_MAX:   m_r    <= (mag_r_r > mag_l_r) ? mag_r_r : mag_l_r;
      ST_DEN:   prod_r <= mul_p;
      ST_CMP: begin
        den_r     <= prod_r[DEN_W-1:0];
        limited_r <= prod_r[DEN_W-1:0] > DEN_W'(lim_r);
      end
      ST_NUM_R: prod_r <= mul_p;
      ST_WAIT_R: begin
        if (div_done) begin
          q_r_r <= div_quot;
        end
      end
      ST_NUM_L: prod_r <= mul_p;
      ST_WAIT_L: begin
        if (div_done) begin
          q_l_r <= div_quot;
        end
      end
      default: ;
    endcase
  end

  assign in_req.ready          = in_ready;
  assign cfg_wr.ready          = rst_n;
  assign out_res.valid         = out_valid_r;
  assign out_res.right_ref     = out_right_r;
  assign out_res.left_ref      = out_left_r;
  assign out_res.accel_limited = out_lim_r;

endmodule
`default_nettype wire

// ===== rtl/core/ddal_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ddal_chk import ddal_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] right_ref,
  input logic signed [OUT_W-1:0] left_ref,
  input logic                    accel_limited
);

  // one request at a time: the sequencer leaves idle on every accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after a request was taken");

  // a new result is only stored while the sequencer is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a request in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(right_ref) && $stable(left_ref) && $stable(accel_limited)))
    else $error("result changed while stalled");

endmodule

bind diff_drive_accel_limited_wheel_refs_unit ddal_chk u_ddal_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_req.valid),
  .in_ready      (in_req.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .right_ref     (out_res.right_ref),
  .left_ref      (out_res.left_ref),
  .accel_limited (out_res.accel_limited)
);
`default_nettype wire
